// ----- hw/rtl/pal_pkg.sv -----
package pal_pkg;

    // List geometry
    localparam int CAPACITY = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 3;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request codes
    localparam logic [2:0] REQ_CLEAR     = 3'd0;
    localparam logic [2:0] REQ_APPEND    = 3'd1;
    localparam logic [2:0] REQ_INS_FIRST = 3'd2;
    localparam logic [2:0] REQ_INS_AT    = 3'd3;
    localparam logic [2:0] REQ_REMOVE_AT = 3'd4;
    localparam logic [2:0] REQ_SEARCH    = 3'd5;

    // Status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [15:0]      item_code;
        logic [7:0]       item_age;
        logic [POS_W-1:0] position;
    } pal_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [15:0] removed_code;
        logic [7:0]  removed_age;
        logic [3:0]  entry_count;
        logic        is_empty;
    } pal_rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } pal_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REPORT
    } pal_state_t;

endpackage

// ----- hw/rtl/pal_ctrl.sv -----
module pal_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output pal_pkg::pal_cmd_t cmd
);
    import pal_pkg::*;

    pal_state_t state_reg;
    pal_state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                state_next = start ? ST_EXEC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive handshake and datapath commands
    always_comb
    begin
        busy     = 1'b0;
        done     = 1'b0;
        cmd.exec = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_EXEC:
            begin
                busy     = 1'b1;
                cmd.exec = 1'b1;
            end
            ST_REPORT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
        cmd.load = start && !busy;
    end

`ifndef SYNTHESIS
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.exec))
        else $error("result strobe without a preceding execute cycle");

    a_exec_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> done)
        else $error("execute cycle not followed by a result strobe");

    a_load_not_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !cmd.exec)
        else $error("new transaction loaded during execution");
`endif

endmodule

// ----- hw/rtl/pal_datapath.sv -----
module pal_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  pal_pkg::pal_cmd_t cmd,
    input  pal_pkg::pal_req_t req,
    output pal_pkg::pal_rsp_t rsp
);
    import pal_pkg::*;

    pal_req_t         req_reg;
    pal_rsp_t         rsp_reg;
    pal_rsp_t         rsp_next;
    logic [15:0]      codes_reg [CAPACITY];
    logic [15:0]      codes_next [CAPACITY];
    logic [7:0]       ages_reg [CAPACITY];
    logic [7:0]       ages_next [CAPACITY];
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CMP_W-1:0] fill_ext;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] ins_idx;
    logic [CMP_W+3:0] cnt_ext;
    logic [IDX_W-1:0] rd_idx;
    logic             full;
    logic             ins_en;
    logic             rem_en;

    assign fill_ext = CMP_W'(fill_reg);
    assign pos_ext  = CMP_W'(req_reg.position);
    assign rd_idx   = pos_ext[IDX_W-1:0];
    assign full     = (fill_ext >= CMP_W'(CAPACITY));

    // Decode the request and work out the new count and result
    always_comb
    begin
        fill_next = fill_reg;
        ins_en    = 1'b0;
        rem_en    = 1'b0;
        ins_idx   = '0;
        rsp_next  = '0;
        rsp_next.status = STAT_OK;
        unique case (req_reg.req_type)
            REQ_CLEAR:
            begin
                fill_next = '0;
            end
            REQ_APPEND, REQ_INS_FIRST, REQ_INS_AT:
            begin
                if (full)
                begin
                    rsp_next.status = STAT_FULL;
                end
                else if (req_reg.req_type == REQ_INS_AT && pos_ext > fill_ext)
                begin
                    rsp_next.status = STAT_BAD;
                end
                else
                begin
                    ins_en    = 1'b1;
                    fill_next = CNT_W'(fill_reg + 1'b1);
                    if (req_reg.req_type == REQ_APPEND)
                    begin
                        ins_idx = fill_ext;
                    end
                    else if (req_reg.req_type == REQ_INS_AT)
                    begin
                        ins_idx = pos_ext;
                    end
                end
            end
            REQ_REMOVE_AT:
            begin
                if (pos_ext >= fill_ext)
                begin
                    rsp_next.status = STAT_BAD;
                end
                else
                begin
                    rem_en                = 1'b1;
                    fill_next             = CNT_W'(fill_reg - 1'b1);
                    rsp_next.removed_code = codes_reg[rd_idx];
                    rsp_next.removed_age  = ages_reg[rd_idx];
                end
            end
            REQ_SEARCH:
            begin
                if (fill_reg == '0)
                begin
                    rsp_next.status = STAT_BAD;
                end
                else
                begin
                    for (int k = 0; k < CAPACITY; k++)
                    begin
                        if (CMP_W'(k) < fill_ext && codes_reg[k] == req_reg.item_code)
                        begin
                            rsp_next.found = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
        cnt_ext              = (CMP_W + 4)'(fill_next);
        rsp_next.entry_count = cnt_ext[3:0];
        rsp_next.is_empty    = (fill_next == '0);
    end

    // Shift the entry cells up on insert, writing the new entry, and down on remove
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            codes_next[k] = codes_reg[k];
            ages_next[k]  = ages_reg[k];
            if (ins_en)
            begin
                if (CMP_W'(k) == ins_idx)
                begin
                    codes_next[k] = req_reg.item_code;
                    ages_next[k]  = req_reg.item_age;
                end
                else if (k != 0 && CMP_W'(k) > ins_idx)
                begin
                    codes_next[k] = codes_reg[(k == 0) ? 0 : k - 1];
                    ages_next[k]  = ages_reg[(k == 0) ? 0 : k - 1];
                end
            end
            else if (rem_en)
            begin
                if (k < CAPACITY - 1 && CMP_W'(k) >= pos_ext)
                begin
                    codes_next[k] = codes_reg[(k < CAPACITY - 1) ? k + 1 : k];
                    ages_next[k]  = ages_reg[(k < CAPACITY - 1) ? k + 1 : k];
                end
            end
        end
    end

    // Hold the count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.exec)
        begin
            fill_reg <= fill_next;
        end
    end

    // Capture the transaction, update cells and the result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            rsp_reg   <= rsp_next;
            codes_reg <= codes_next;
            ages_reg  <= ages_next;
        end
    end

    assign rsp = rsp_reg;

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_ext <= CMP_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_fill_held: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(fill_reg))
        else $error("entry count changed outside execution");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (rsp_reg.is_empty == (fill_reg == '0)))
        else $error("empty flag disagrees with entry count");

    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && rsp_next.status == STAT_FULL |=> $stable(fill_reg))
        else $error("entry count changed on a full list");
`endif

endmodule

// ----- hw/rtl/positional_array_list.sv -----
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------
// request  | start in, busy out         | req  (pal_req_t)
// result   | done out, one-cycle strobe | rsp  (pal_rsp_t)
//
// A request is taken when start is high and busy is low; its result is registered
// at the end of the execute step and shown on rsp with done high for one cycle.
// Each request passes a load step, then an execute step (busy high, no new request
// taken) in which all entry cells shift and compare in parallel.
// A new request may be taken in the cycle that shows the previous result.
// Reset clears the entry count only; stored entries are undefined until written.
// The receiver cannot stall: each result must be taken in its strobe cycle.
module positional_array_list (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pal_pkg::pal_req_t req,
    output logic              done,
    output pal_pkg::pal_rsp_t rsp
);
    import pal_pkg::*;

    pal_cmd_t cmd;

    // Sequence each transaction
    pal_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Hold the list and compute results
    pal_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
